### rtl/jddm_pkg.sv
// Shared types and constants for the joystick differential-drive mixer.
// Holds the state, mode and step codes plus the Q16 coefficients.
// No dependencies.
`default_nettype none

package jddm_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned CMP_W  = 13;
  localparam int unsigned A_W    = 19;
  localparam int unsigned B_W    = 17;
  localparam int unsigned ACC_W  = A_W + B_W;
  localparam int unsigned FRAC_W = 16;

  typedef enum logic [2:0] {
    MODE_STOP   = 3'd0,
    MODE_FWD    = 3'd1,
    MODE_REV    = 3'd2,
    MODE_SPIN_L = 3'd3,
    MODE_SPIN_R = 3'd4
  } drive_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_BASE,
    ST_RIGHT,
    ST_LEFT,
    ST_STORE,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SCALE,
    OP_BASE,
    OP_RIGHT,
    OP_LEFT
  } op_t;

  typedef struct packed {
    logic take;
    op_t  op;
    logic cap_base;
    logic cap_right;
    logic cap_left;
  } ctrl_t;

  // Q16 coefficients, truncated.
  localparam logic [A_W-1:0]   K_STEER_L  = 19'd137;
  localparam logic [A_W-1:0]   K_STEER_R  = 19'd124;
  localparam logic [A_W-1:0]   K_REV      = 19'd437780;
  localparam logic [A_W-1:0]   K_FWD      = 19'd403046;
  localparam logic [A_W-1:0]   K_SPIN     = 19'd6400;
  localparam logic [B_W-1:0]   SC_ONE     = 17'd65536;
  localparam logic [ACC_W-1:0] K_Q_ONE    = 36'd65536;
  localparam logic [ACC_W-1:0] K_REV_OFS  = 36'd117964800;
  localparam logic [ACC_W-1:0] K_FWD_OFS  = 36'd333709312;
  localparam logic [ACC_W-1:0] K_SPIN_OFS = 36'd537395200;

  // Throttle and steering thresholds.
  localparam logic [WORD_W-1:0] T_GUARD_HI = 16'd950;
  localparam logic [WORD_W-1:0] T_GUARD_LO = 16'd100;
  localparam logic [WORD_W-1:0] T_SLOW_REV = 16'd540;
  localparam logic [WORD_W-1:0] T_SLOW_FWD = 16'd470;
  localparam logic [WORD_W-1:0] T_REV_LO   = 16'd516;
  localparam logic [WORD_W-1:0] T_REV_HI   = 16'd1029;
  localparam logic [WORD_W-1:0] T_REV_ZERO = 16'd510;
  localparam logic [WORD_W-1:0] T_FWD_LO   = 16'd1;
  localparam logic [WORD_W-1:0] T_FWD_HI   = 16'd479;
  localparam logic [WORD_W-1:0] S_LEFT_LO  = 16'd1;
  localparam logic [WORD_W-1:0] S_LEFT_HI  = 16'd470;
  localparam logic [WORD_W-1:0] S_RIGHT_LO = 16'd520;
  localparam logic [WORD_W-1:0] S_RIGHT_HI = 16'd1024;
  localparam logic [WORD_W-1:0] HORN_CODE  = 16'd1;

endpackage

`default_nettype wire

### rtl/jddm_mac.sv
// Shared multiply-add unit: r = k + a*b or k - a*b, registered.
// Depends on jddm_pkg for operand widths.
`default_nettype none

module jddm_mac (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic                          sub,
  input  wire logic [jddm_pkg::A_W-1:0]      a,
  input  wire logic [jddm_pkg::B_W-1:0]      b,
  input  wire logic [jddm_pkg::ACC_W-1:0]    k,
  output logic      [jddm_pkg::ACC_W-1:0]    r_r
);

  logic [jddm_pkg::ACC_W-1:0] prod;
  logic [jddm_pkg::ACC_W-1:0] r_nxt;

  assign prod  = jddm_pkg::ACC_W'(a) * jddm_pkg::ACC_W'(b);
  assign r_nxt = sub ? (k - prod) : (k + prod);

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/jddm_ctrl.sv
// Step sequencer for the mixer: walks a drive item through the shared unit.
// Depends on jddm_pkg for the state, step and control types.
`default_nettype none

module jddm_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_action,
  input  wire logic            out_ready,
  output logic                 in_ready,
  output logic                 out_valid,
  output jddm_pkg::ctrl_t      ctrl
);

  jddm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jddm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jddm_pkg::ST_IDLE: begin
        if (in_valid && !in_action) state_nxt = jddm_pkg::ST_SCALE;
      end
      jddm_pkg::ST_SCALE: state_nxt = jddm_pkg::ST_BASE;
      jddm_pkg::ST_BASE:  state_nxt = jddm_pkg::ST_RIGHT;
      jddm_pkg::ST_RIGHT: state_nxt = jddm_pkg::ST_LEFT;
      jddm_pkg::ST_LEFT:  state_nxt = jddm_pkg::ST_STORE;
      jddm_pkg::ST_STORE: state_nxt = jddm_pkg::ST_OUT;
      jddm_pkg::ST_OUT: begin
        if (out_ready) state_nxt = jddm_pkg::ST_IDLE;
      end
      default: state_nxt = jddm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    ctrl.take      = 1'b0;
    ctrl.op        = jddm_pkg::OP_NONE;
    ctrl.cap_base  = 1'b0;
    ctrl.cap_right = 1'b0;
    ctrl.cap_left  = 1'b0;
    unique case (state_r)
      jddm_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.take = in_valid;
      end
      jddm_pkg::ST_SCALE: ctrl.op = jddm_pkg::OP_SCALE;
      jddm_pkg::ST_BASE:  ctrl.op = jddm_pkg::OP_BASE;
      jddm_pkg::ST_RIGHT: begin
        ctrl.op       = jddm_pkg::OP_RIGHT;
        ctrl.cap_base = 1'b1;
      end
      jddm_pkg::ST_LEFT: begin
        ctrl.op        = jddm_pkg::OP_LEFT;
        ctrl.cap_right = 1'b1;
      end
      jddm_pkg::ST_STORE: ctrl.cap_left = 1'b1;
      jddm_pkg::ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/joystick_differential_drive_mixer.sv
// Top level of the joystick differential-drive mixer.
// Depends on jddm_pkg, jddm_ctrl and jddm_mac.
`default_nettype none

// A drive item keeps the block busy from acceptance until its result is
// taken, and the next item can be taken only after that. The work is four
// passes through the one shared multiply-add unit (side scaler, base value,
// right compare, left compare), a step that captures the left compare and
// the output step, which offers the result until it is taken; in_ready then
// rises again in the idle state.
// A clear item is taken in the idle state without leaving it, resets both
// reversal guard flags and gives no result. in_ready is low while a drive
// item is in work.

module joystick_differential_drive_mixer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_action,
  input  wire logic [jddm_pkg::WORD_W-1:0]       in_throttle_word,
  input  wire logic [jddm_pkg::WORD_W-1:0]       in_steer_word,
  input  wire logic [jddm_pkg::WORD_W-1:0]       in_horn_word,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [jddm_pkg::CMP_W-1:0]        out_right_compare,
  output logic      [jddm_pkg::CMP_W-1:0]        out_left_compare,
  output logic                                   out_right_reverse,
  output logic                                   out_left_reverse,
  output logic      [2:0]                        out_drive_mode,
  output logic                                   out_horn_on
);

  jddm_pkg::ctrl_t ctrl;

  logic fwd_guard_r, fwd_guard_nxt;
  logic rev_guard_r, rev_guard_nxt;

  logic [jddm_pkg::WORD_W-1:0] t_adj;
  logic                        is_left, is_right, is_spin_r;
  jddm_pkg::drive_mode_t       mode_nxt;

  logic [jddm_pkg::WORD_W-1:0] t_r;
  logic [jddm_pkg::WORD_W-1:0] s_r;
  logic                        left_r, right_r, horn_r;
  jddm_pkg::drive_mode_t       mode_r;

  logic [jddm_pkg::B_W-1:0]    lsc_r, rsc_r, steered;
  logic [jddm_pkg::CMP_W-1:0]  base_r, rc_r, lc_r, prod_cmp;

  logic                        mac_en, mac_sub;
  logic [jddm_pkg::A_W-1:0]    mac_a;
  logic [jddm_pkg::B_W-1:0]    mac_b;
  logic [jddm_pkg::ACC_W-1:0]  mac_k, mac_r;

  jddm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  jddm_mac u_mac (
    .clk (clk),
    .en  (mac_en),
    .sub (mac_sub),
    .a   (mac_a),
    .b   (mac_b),
    .k   (mac_k),
    .r_r (mac_r)
  );

  // Guard flags turn a full-power reversal into a slow speed.
  always_comb begin
    t_adj         = in_throttle_word;
    fwd_guard_nxt = fwd_guard_r;
    rev_guard_nxt = rev_guard_r;
    if (ctrl.take) begin
      if (in_action) begin
        fwd_guard_nxt = 1'b0;
        rev_guard_nxt = 1'b0;
      end else if (in_throttle_word > jddm_pkg::T_GUARD_HI) begin
        if (fwd_guard_r) t_adj = jddm_pkg::T_SLOW_REV;
        rev_guard_nxt = 1'b1;
      end else if (in_throttle_word < jddm_pkg::T_GUARD_LO) begin
        if (rev_guard_r) t_adj = jddm_pkg::T_SLOW_FWD;
        fwd_guard_nxt = 1'b1;
      end
    end
  end

  assign is_left   = (in_steer_word >= jddm_pkg::S_LEFT_LO) &&
                     (in_steer_word <= jddm_pkg::S_LEFT_HI);
  assign is_right  = (in_steer_word >= jddm_pkg::S_RIGHT_LO) &&
                     (in_steer_word <= jddm_pkg::S_RIGHT_HI);
  // At the lower edge of the right range the scaler is exactly one.
  assign is_spin_r = is_right && (in_steer_word != jddm_pkg::S_RIGHT_LO);

  always_comb begin
    if ((t_adj >= jddm_pkg::T_REV_LO) && (t_adj <= jddm_pkg::T_REV_HI)) begin
      mode_nxt = jddm_pkg::MODE_REV;
    end else if ((t_adj >= jddm_pkg::T_FWD_LO) && (t_adj <= jddm_pkg::T_FWD_HI)) begin
      mode_nxt = jddm_pkg::MODE_FWD;
    end else if (is_left) begin
      mode_nxt = jddm_pkg::MODE_SPIN_L;
    end else if (is_spin_r) begin
      mode_nxt = jddm_pkg::MODE_SPIN_R;
    end else begin
      mode_nxt = jddm_pkg::MODE_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_guard_r <= 1'b0;
      rev_guard_r <= 1'b0;
    end else begin
      fwd_guard_r <= fwd_guard_nxt;
      rev_guard_r <= rev_guard_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take && !in_action) begin
      t_r     <= t_adj;
      s_r     <= in_steer_word;
      left_r  <= is_left;
      right_r <= is_right;
      mode_r  <= mode_nxt;
      horn_r  <= (in_horn_word == jddm_pkg::HORN_CODE);
    end
  end

  // The scaler of the steered side sits in the unit's result during the base step.
  assign steered  = mac_r[jddm_pkg::B_W-1:0];
  assign prod_cmp = mac_r[jddm_pkg::FRAC_W +: jddm_pkg::CMP_W];

  always_comb begin
    mac_en  = (ctrl.op != jddm_pkg::OP_NONE);
    mac_sub = 1'b0;
    mac_a   = '0;
    mac_b   = '0;
    mac_k   = '0;
    unique case (ctrl.op)
      jddm_pkg::OP_SCALE: begin
        if (left_r) begin
          mac_a = jddm_pkg::K_STEER_L;
          mac_b = {1'b0, s_r};
        end else if (right_r) begin
          mac_sub = 1'b1;
          mac_k   = jddm_pkg::K_Q_ONE;
          mac_a   = jddm_pkg::K_STEER_R;
          mac_b   = {1'b0, s_r - jddm_pkg::S_RIGHT_LO};
        end else begin
          mac_k = jddm_pkg::K_Q_ONE;
        end
      end
      jddm_pkg::OP_BASE: begin
        unique case (mode_r)
          jddm_pkg::MODE_REV: begin
            mac_k = jddm_pkg::K_REV_OFS;
            mac_a = jddm_pkg::K_REV;
            mac_b = {1'b0, t_r - jddm_pkg::T_REV_ZERO};
          end
          jddm_pkg::MODE_FWD: begin
            mac_sub = 1'b1;
            mac_k   = jddm_pkg::K_FWD_OFS;
            mac_a   = jddm_pkg::K_FWD;
            mac_b   = {1'b0, t_r};
          end
          jddm_pkg::MODE_SPIN_L, jddm_pkg::MODE_SPIN_R: begin
            mac_sub = 1'b1;
            mac_k   = jddm_pkg::K_SPIN_OFS;
            mac_a   = jddm_pkg::K_SPIN;
            mac_b   = steered;
          end
          default: ;
        endcase
      end
      jddm_pkg::OP_RIGHT: begin
        mac_a = {{(jddm_pkg::A_W - jddm_pkg::CMP_W){1'b0}}, prod_cmp};
        mac_b = rsc_r;
      end
      jddm_pkg::OP_LEFT: begin
        mac_a = {{(jddm_pkg::A_W - jddm_pkg::CMP_W){1'b0}}, base_r};
        mac_b = lsc_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == jddm_pkg::OP_BASE) begin
      lsc_r <= left_r ? steered : jddm_pkg::SC_ONE;
      rsc_r <= left_r ? jddm_pkg::SC_ONE : steered;
    end
    if (ctrl.cap_base) begin
      base_r <= prod_cmp;
    end
    if (ctrl.cap_right) begin
      unique case (mode_r)
        jddm_pkg::MODE_REV, jddm_pkg::MODE_FWD:       rc_r <= prod_cmp;
        jddm_pkg::MODE_SPIN_L, jddm_pkg::MODE_SPIN_R: rc_r <= base_r;
        default:                                      rc_r <= '0;
      endcase
    end
    if (ctrl.cap_left) begin
      unique case (mode_r)
        jddm_pkg::MODE_REV, jddm_pkg::MODE_FWD:       lc_r <= prod_cmp;
        jddm_pkg::MODE_SPIN_L, jddm_pkg::MODE_SPIN_R: lc_r <= base_r;
        default:                                      lc_r <= '0;
      endcase
    end
  end

  assign out_right_compare = rc_r;
  assign out_left_compare  = lc_r;
  assign out_right_reverse = (mode_r == jddm_pkg::MODE_REV) ||
                             (mode_r == jddm_pkg::MODE_SPIN_R);
  assign out_left_reverse  = (mode_r == jddm_pkg::MODE_REV) ||
                             (mode_r == jddm_pkg::MODE_SPIN_L);
  assign out_drive_mode    = mode_r;
  assign out_horn_on       = horn_r;

endmodule

`default_nettype wire

### rtl/jddm_checker.sv
// Port-level checks for the mixer, attached to the top level by bind.
// Depends on jddm_pkg for the drive mode codes.
`default_nettype none

module jddm_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         in_action,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [jddm_pkg::CMP_W-1:0]   out_right_compare,
  input wire logic [jddm_pkg::CMP_W-1:0]   out_left_compare,
  input wire logic                         out_right_reverse,
  input wire logic                         out_left_reverse,
  input wire logic [2:0]                   out_drive_mode
);

  // The block works on one item at a time.
  a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // A drive item keeps the block busy in the next cycle.
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_action) |=> !in_ready)
    else $error("block ready right after taking a drive item");

  // Stop gives zero compares and no reversal.
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drive_mode == jddm_pkg::MODE_STOP) |->
      (out_right_compare == '0 && out_left_compare == '0 &&
       !out_right_reverse && !out_left_reverse))
    else $error("stop result not idle");

  // Spin drives both sides alike with exactly one side reversed.
  a_spin_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_drive_mode == jddm_pkg::MODE_SPIN_L ||
                   out_drive_mode == jddm_pkg::MODE_SPIN_R)) |->
      (out_right_compare == out_left_compare &&
       (out_right_reverse != out_left_reverse)))
    else $error("spin result malformed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_right_compare) && $stable(out_left_compare) &&
       $stable(out_drive_mode)))
    else $error("stalled result changed");

endmodule

bind joystick_differential_drive_mixer jddm_checker u_jddm_checker (.*);

`default_nettype wire
